@@ hw/rtl/lru_page_replacement_macros.svh @@
// assertion macros for the lru page replacement block
// used by the top level only; needs i_clk and i_rst_n in scope
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

// same-cycle implication
`define LRUPR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LRUPR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/lrupr_pkg.sv @@
// types and constants shared by the lru page replacement block
// no dependencies
`timescale 1ns / 1ps

package lrupr_pkg;

    localparam int FRAMES    = 8;
    localparam int PAGE_BITS = 16;
    localparam int SLOT_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int RANK_W    = SLOT_W;
    localparam int CNT_W     = $clog2(FRAMES + 1);
    localparam int CFG_W     = 4;
    localparam int COUNT_W   = 32;

    localparam logic [CFG_W-1:0]  CFG_RESET = CFG_W'(8);
    localparam logic [RANK_W-1:0] RANK_MAX  = RANK_W'(FRAMES - 1);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } t_state;

    // record carried from cell to cell during a lookup
    typedef struct packed {
        logic                 valid;
        logic [PAGE_BITS-1:0] key;
        logic                 found;
        logic [SLOT_W-1:0]    hit_slot;
        logic [RANK_W-1:0]    hit_rank;
        logic                 empty_found;
        logic [SLOT_W-1:0]    empty_slot;
        logic                 best_set;
        logic [RANK_W-1:0]    best_rank;
        logic [SLOT_W-1:0]    best_slot;
        logic [PAGE_BITS-1:0] best_page;
    } t_scan;

    // update broadcast to every cell once the decision is made
    typedef struct packed {
        logic                 en;
        logic                 miss;
        logic [SLOT_W-1:0]    slot;
        logic [RANK_W-1:0]    hit_rank;
        logic [PAGE_BITS-1:0] key;
    } t_upd;

endpackage

@@ hw/rtl/lru_page_replacement.sv @@
// lru page frame table top level: chain of frame cells plus control; uses lrupr_pkg, lrupr_cell
// an accepted word walks the cell chain, registered in each cell, and its result strobe is registered after it
// a new word is not accepted while busy, that is until the lookup record has left the cell chain
// busy falls in the strobe cycle, so the next word may be accepted then; results cannot stall
// reset (synchronous, active low): all frames empty, ranks and counters zero, frame count setting 8
`timescale 1ns / 1ps
`include "lru_page_replacement_macros.svh"

module lru_page_replacement (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [lrupr_pkg::PAGE_BITS-1:0] i_page_number,
    output logic                            o_strobe,
    output logic                            o_hit,
    output logic [lrupr_pkg::SLOT_W-1:0]    o_frame_slot,
    output logic                            o_evicted_valid,
    output logic [lrupr_pkg::PAGE_BITS-1:0] o_evicted_page,
    output logic [lrupr_pkg::COUNT_W-1:0]   o_fault_count,
    output logic [lrupr_pkg::COUNT_W-1:0]   o_reference_count,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lrupr_pkg::CFG_W-1:0]     i_cfg_data
);
    import lrupr_pkg::*;

    t_state               r_state, n_state;
    logic [CFG_W-1:0]     r_cfg;
    logic [CNT_W-1:0]     n_act;
    logic                 accept;
    t_scan                chain [FRAMES+1];
    t_scan                last;
    t_upd                 upd;

    logic                 r_strobe, n_strobe;
    logic                 r_hit, n_hit;
    logic [SLOT_W-1:0]    r_slot, n_slot;
    logic                 r_ev_valid, n_ev_valid;
    logic [PAGE_BITS-1:0] r_ev_page, n_ev_page;
    logic [COUNT_W-1:0]   r_faults, n_faults;
    logic [COUNT_W-1:0]   r_refs, n_refs;

    assign busy        = (r_state != ST_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = !busy && !start;

    always_comb begin
        if (r_cfg == '0) begin
            n_act = CNT_W'(1);
        end else if (int'(r_cfg) > FRAMES) begin
            n_act = CNT_W'(FRAMES);
        end else begin
            n_act = CNT_W'(r_cfg);
        end
    end

    always_comb begin
        chain[0]       = '0;
        chain[0].valid = accept;
        chain[0].key   = i_page_number;
    end

    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        lrupr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (SLOT_W'(g)),
            .i_n_act (n_act),
            .i_scan  (chain[g]),
            .o_scan  (chain[g+1]),
            .i_upd   (upd)
        );
    end

    assign last = chain[FRAMES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cfg    <= CFG_RESET;
            r_strobe <= 1'b0;
            r_faults <= '0;
            r_refs   <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_faults <= n_faults;
            r_refs   <= n_refs;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit      <= n_hit;
        r_slot     <= n_slot;
        r_ev_valid <= n_ev_valid;
        r_ev_page  <= n_ev_page;
    end

    always_comb begin
        n_state    = r_state;
        n_strobe   = 1'b0;
        n_hit      = r_hit;
        n_slot     = r_slot;
        n_ev_valid = r_ev_valid;
        n_ev_page  = r_ev_page;
        n_faults   = r_faults;
        n_refs     = r_refs;
        upd        = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (last.valid) begin
                    n_state    = ST_IDLE;
                    n_strobe   = 1'b1;
                    n_hit      = last.found;
                    n_ev_valid = !last.found && !last.empty_found;
                    n_ev_page  = n_ev_valid ? last.best_page : '0;
                    if (last.found) begin
                        n_slot = last.hit_slot;
                    end else if (last.empty_found) begin
                        n_slot = last.empty_slot;
                    end else begin
                        n_slot = last.best_slot;
                    end
                    upd.en       = 1'b1;
                    upd.miss     = !last.found;
                    upd.slot     = n_slot;
                    upd.hit_rank = last.hit_rank;
                    upd.key      = last.key;
                    if (r_refs != '1) begin
                        n_refs = r_refs + COUNT_W'(1);
                    end
                    if (!last.found && (r_faults != '1)) begin
                        n_faults = r_faults + COUNT_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_strobe          = r_strobe;
    assign o_hit             = r_hit;
    assign o_frame_slot      = r_slot;
    assign o_evicted_valid   = r_ev_valid;
    assign o_evicted_page    = r_ev_page;
    assign o_fault_count     = r_faults;
    assign o_reference_count = r_refs;

    `LRUPR_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted word did not raise busy")
    `LRUPR_ASSERT_NOW(a_strobe_idle, o_strobe, !busy, "result strobe while still busy")
    `LRUPR_ASSERT_NOW(a_evict_miss, o_strobe && o_evicted_valid, !o_hit, "eviction on a hit")
    `LRUPR_ASSERT_NOW(a_count_order, o_strobe, o_fault_count <= o_reference_count, "faults exceed refs")

endmodule

@@ hw/rtl/lrupr_cell.sv @@
// one page frame: page, valid bit and recency rank, plus one lookup stage
// depends on lrupr_pkg
`timescale 1ns / 1ps

module lrupr_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [lrupr_pkg::SLOT_W-1:0] i_index,
    input  logic [lrupr_pkg::CNT_W-1:0]  i_n_act,
    input  lrupr_pkg::t_scan            i_scan,
    output lrupr_pkg::t_scan            o_scan,
    input  lrupr_pkg::t_upd             i_upd
);
    import lrupr_pkg::*;

    logic [PAGE_BITS-1:0] r_page;
    logic                 r_valid;
    logic [RANK_W-1:0]    r_rank;
    t_scan                r_scan;
    t_scan                n_scan;
    logic                 active;
    logic                 age;

    assign active = CNT_W'(i_index) < i_n_act;

    always_comb begin
        n_scan = i_scan;
        if (active) begin
            if (r_valid && (r_page == i_scan.key) && !i_scan.found) begin
                n_scan.found    = 1'b1;
                n_scan.hit_slot = i_index;
                n_scan.hit_rank = r_rank;
            end
            if (!r_valid && !i_scan.empty_found) begin
                n_scan.empty_found = 1'b1;
                n_scan.empty_slot  = i_index;
            end
            if (!i_scan.best_set || (r_rank > i_scan.best_rank)) begin
                n_scan.best_set  = 1'b1;
                n_scan.best_rank = r_rank;
                n_scan.best_slot = i_index;
                n_scan.best_page = r_page;
            end
        end
    end

    assign age = active && r_valid &&
                 (i_upd.miss ? (r_rank != RANK_MAX) : (r_rank < i_upd.hit_rank));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
            r_scan  <= '0;
        end else begin
            r_scan <= n_scan;
            if (i_upd.en) begin
                if (i_upd.slot == i_index) begin
                    r_rank <= '0;
                    if (i_upd.miss) begin
                        r_valid <= 1'b1;
                    end
                end else if (age) begin
                    r_rank <= r_rank + RANK_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.en && i_upd.miss && (i_upd.slot == i_index)) begin
            r_page <= i_upd.key;
        end
    end

    assign o_scan = r_scan;

endmodule

@@ sim/tb_lru_page_replacement.sv @@
// testbench for the lru page frame table: page references go in over start/busy and each
// result strobe is checked field by field against a behavioural model of the table
// depends on lrupr_pkg and lru_page_replacement
`timescale 1ns / 1ps

module tb_lru_page_replacement;
    import lrupr_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 12;
    localparam int LATENCY      = FRAMES + 1;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_WORDS = 500;
    localparam int REPORT_MAX   = 10;

    typedef struct {
        logic                 hit;
        logic [SLOT_W-1:0]    slot;
        logic                 evicted_valid;
        logic [PAGE_BITS-1:0] evicted_page;
        logic [COUNT_W-1:0]   faults;
        logic [COUNT_W-1:0]   references;
    } t_page_outcome;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [PAGE_BITS-1:0] i_page_number = '0;
    logic                 o_strobe;
    logic                 o_hit;
    logic [SLOT_W-1:0]    o_frame_slot;
    logic                 o_evicted_valid;
    logic [PAGE_BITS-1:0] o_evicted_page;
    logic [COUNT_W-1:0]   o_fault_count;
    logic [COUNT_W-1:0]   o_reference_count;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_W-1:0]     i_cfg_data = CFG_RESET;

    // frame table as the block should hold it
    logic [PAGE_BITS-1:0] table_page [FRAMES];
    logic                 table_valid [FRAMES];
    logic [RANK_W-1:0]    table_rank [FRAMES];
    logic [COUNT_W-1:0]   fault_total;
    logic [COUNT_W-1:0]   reference_total;
    logic [CFG_W-1:0]     frames_setting;

    t_page_outcome expected_outcomes[$];

    int  cycle_count = 0;
    int  mismatch_count = 0;
    int  words_sent = 0;
    int  hits_seen = 0;
    int  evictions_seen = 0;
    int  cfg_writes = 0;
    bit  sender_gaps = 1'b0;

    lru_page_replacement uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_page_number     (i_page_number),
        .o_strobe          (o_strobe),
        .o_hit             (o_hit),
        .o_frame_slot      (o_frame_slot),
        .o_evicted_valid   (o_evicted_valid),
        .o_evicted_page    (o_evicted_page),
        .o_fault_count     (o_fault_count),
        .o_reference_count (o_reference_count),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     expected_outcomes.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic void clear_table();
        for (int i = 0; i < FRAMES; i++) begin
            table_page[i]  = '0;
            table_valid[i] = 1'b0;
            table_rank[i]  = '0;
        end
        fault_total     = '0;
        reference_total = '0;
        frames_setting  = CFG_RESET;
    endfunction

    // look the page up, update the table and return the result the block owes
    function automatic t_page_outcome lookup_page(logic [PAGE_BITS-1:0] page);
        t_page_outcome     res;
        int                active;
        int                slot;
        int                i;
        bit                found;
        bit                empty;
        logic [RANK_W-1:0] limit;
        logic [RANK_W-1:0] best;
        if (frames_setting == 0)
            active = 1;
        else if (frames_setting > FRAMES)
            active = FRAMES;
        else
            active = int'(frames_setting);
        slot  = 0;
        found = 1'b0;
        empty = 1'b0;
        res.evicted_valid = 1'b0;
        res.evicted_page  = '0;
        if (reference_total != '1)
            reference_total++;
        for (i = 0; i < active; i++) begin
            if (!found && table_valid[i] && table_page[i] == page) begin
                slot  = i;
                found = 1'b1;
            end
        end
        if (found) begin
            limit = table_rank[slot];
        end else begin
            limit = RANK_MAX;
            for (i = 0; i < active; i++) begin
                if (!empty && !table_valid[i]) begin
                    slot  = i;
                    empty = 1'b1;
                end
            end
            if (!empty) begin
                // oldest active frame, lowest index on a tie
                best = table_rank[0];
                slot = 0;
                for (i = 1; i < active; i++) begin
                    if (table_rank[i] > best) begin
                        best = table_rank[i];
                        slot = i;
                    end
                end
                res.evicted_valid = 1'b1;
                res.evicted_page  = table_page[slot];
            end
            table_page[slot]  = page;
            table_valid[slot] = 1'b1;
            if (fault_total != '1)
                fault_total++;
        end
        for (i = 0; i < active; i++) begin
            if (i != slot && table_valid[i] && table_rank[i] < limit)
                table_rank[i]++;
        end
        table_rank[slot] = '0;
        res.hit        = found;
        res.slot       = SLOT_W'(slot);
        res.faults     = fault_total;
        res.references = reference_total;
        return res;
    endfunction

    task automatic note_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
            note_error($sformatf("%s expected %0h, got %0h", name, want, got));
    endtask

    always @(posedge i_clk) begin
        t_page_outcome want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (expected_outcomes.size() == 0) begin
                note_error("result strobe with no reference outstanding");
            end else begin
                want = expected_outcomes.pop_front();
                check_field("hit", 64'(want.hit), 64'(o_hit));
                check_field("frame_slot", 64'(want.slot), 64'(o_frame_slot));
                check_field("evicted_valid", 64'(want.evicted_valid), 64'(o_evicted_valid));
                check_field("evicted_page", 64'(want.evicted_page), 64'(o_evicted_page));
                check_field("fault_count", 64'(want.faults), 64'(o_fault_count));
                check_field("reference_count", 64'(want.references),
                            64'(o_reference_count));
            end
        end
    end

    // present one page word and hold it until the block takes it
    task automatic send_page(input logic [PAGE_BITS-1:0] page);
        t_page_outcome outcome;
        i_page_number <= page;
        start <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        outcome = lookup_page(page);
        expected_outcomes.push_back(outcome);
        words_sent++;
        if (outcome.hit)
            hits_seen++;
        if (outcome.evicted_valid)
            evictions_seen++;
        if (sender_gaps && $urandom_range(99) < 17) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // stop sending and let every outstanding result come back
    task automatic wait_idle();
        start <= 1'b0;
        while (expected_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_frames(input logic [CFG_W-1:0] value);
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        frames_setting = value;
        cfg_writes++;
        @(posedge i_clk);
    endtask

    task automatic test_fill_and_hit();
        sender_gaps = 1'b0;
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h0001);
        send_page(16'h8000);
        send_page(16'h5555);
        send_page(16'hAAAA);
        send_page(16'h1234);
        send_page(16'h00FF);
        send_page(16'h0000);
        send_page(16'hAAAA);
        wait_idle();
    endtask

    task automatic test_eviction();
        sender_gaps = 1'b1;
        send_page(16'h4242);
        send_page(16'hFFFF);
        wait_idle();
    endtask

    task automatic test_frame_count();
        sender_gaps = 1'b1;
        write_frames(CFG_W'(2));
        send_page(16'hFFFF);
        // page still held in a frame outside the count, so this duplicates it
        send_page(16'h1234);
        wait_idle();
        write_frames(CFG_W'(15));
        send_page(16'h1234);
        send_page(16'h0101);
        wait_idle();
        write_frames(CFG_W'(0));
        send_page(16'h7777);
        send_page(16'h7777);
        wait_idle();
        write_frames(CFG_W'(8));
        send_page(16'h0F0F);
        send_page(16'hF0F0);
        send_page(16'h3C3C);
        send_page(16'hC3C3);
        send_page(16'h9999);
        wait_idle();
    endtask

    task automatic test_random();
        logic [PAGE_BITS-1:0] pool [16];
        logic [PAGE_BITS-1:0] page;
        int                   pool_size;
        int                   block;
        int                   burst;
        int                   sent;
        int                   roll;
        int                   k;
        sent  = 0;
        block = 0;
        while (sent < RANDOM_WORDS) begin
            wait_idle();
            if (block == 0)
                write_frames(CFG_W'(1));
            else if ($urandom_range(1))
                write_frames(CFG_W'($urandom_range(1, FRAMES)));
            else
                write_frames(CFG_W'($urandom_range(0, 15)));
            pool_size = $urandom_range(2, 12);
            for (k = 0; k < pool_size; k++)
                pool[k] = PAGE_BITS'($urandom);
            // one stretch with the sender's random gaps turned off
            sender_gaps = (block != 2);
            burst = $urandom_range(30, 70);
            for (k = 0; k < burst; k++) begin
                roll = $urandom_range(99);
                if (roll < 70) begin
                    page = pool[$urandom_range(0, pool_size - 1)];
                end else if (roll < 80) begin
                    case ($urandom_range(3))
                        0: page = '0;
                        1: page = '1;
                        2: page = PAGE_BITS'(1) << $urandom_range(0, PAGE_BITS - 1);
                        default: page = ~(PAGE_BITS'(1) << $urandom_range(0, PAGE_BITS - 1));
                    endcase
                end else begin
                    page = PAGE_BITS'($urandom);
                end
                send_page(page);
                sent++;
                if ($urandom_range(49) == 0)
                    wait_idle();
            end
            block++;
        end
        wait_idle();
    endtask

    initial begin
        clear_table();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_fill_and_hit();
        test_eviction();
        test_frame_count();
        test_random();
        wait_idle();
        $display("%0d page references: %0d hits, %0d evictions, %0d frame count writes",
                 words_sent, hits_seen, evictions_seen, cfg_writes);
        $display("%0d result mismatches", mismatch_count);
        if (mismatch_count == 0 && expected_outcomes.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
